// ----- src/ofcp_pkg.sv -----
// shared types, constants and the crc-8 byte update for the odometry frame parser
package ofcp_pkg;

  localparam int unsigned FrameBytes = 23;
  localparam logic [4:0]  PosMax     = 5'd31;
  localparam logic [4:0]  PosLastCrc = 5'd20;
  localparam logic [4:0]  PosCrc     = 5'd21;
  localparam logic [4:0]  PosFrameEnd = 5'(FrameBytes - 1);
  localparam logic [7:0]  HeaderByte = 8'h58;
  localparam logic [7:0]  TrailerByte = 8'h0A;
  localparam logic [7:0]  CrcPolyRefl = 8'h8C;
  localparam logic [7:0]  CrcInit    = 8'h00;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_HEADER  = 3'd2,
    ST_TRAILER = 3'd3,
    ST_CRC     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  // reflected crc-8, lsb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = crc_in;
    d   = data;
    for (int b = 0; b < 8; b++) begin
      mix = crc[0] ^ d[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPolyRefl;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

// ----- src/ofcp_in_stage.sv -----
// input register stage of the odometry frame parser
module ofcp_in_stage
  import ofcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  byte_item_t in_item,
  output logic       s_valid,
  input  logic       s_ready,
  output byte_item_t s_item
);

  logic       s_valid_r;
  byte_item_t s_item_r;

  assign in_ready = !s_valid_r || s_ready;
  assign s_valid  = s_valid_r;
  assign s_item   = s_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid_r <= 1'b1;
    end else if (s_ready) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_item;
    end
  end

endmodule

// ----- src/ofcp_frame_chk.sv -----
// frame state, crc check and result register of the odometry frame parser
module ofcp_frame_chk
  import ofcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_valid,
  output logic        s_ready,
  input  byte_item_t  s_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_status,
  output logic [31:0] out_stamp_seconds,
  output logic [31:0] out_stamp_millis,
  output logic [31:0] out_pos_x_bits,
  output logic [31:0] out_pos_y_bits,
  output logic [31:0] out_heading_bits
);

  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [7:0]  rx_crc_r, rx_crc_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] y_r, y_nxt;
  logic [31:0] yaw_r, yaw_nxt;

  logic        out_valid_r;
  status_t     status_r, status_nxt;
  logic [31:0] o_sec_r, o_ms_r, o_x_r, o_y_r, o_yaw_r;

  logic        take;
  logic        res_load;
  logic [7:0]  b;
  logic [4:0]  count;

  // a non-last item never needs the result register
  assign s_ready  = !s_item.last_byte || !out_valid_r || out_ready;
  assign take     = s_valid && s_ready;
  assign res_load = take && s_item.last_byte;
  assign b        = s_item.data_byte;
  assign count    = (pos_r < PosMax) ? pos_r + 5'd1 : PosMax;

  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    crc_nxt    = crc_r;
    rx_crc_nxt = rx_crc_r;
    sec_nxt    = sec_r;
    ms_nxt     = ms_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    yaw_nxt    = yaw_r;
    if (pos_r == 5'd0) begin
      hdr_ok_nxt = (b == HeaderByte);
    end
    if (pos_r <= PosLastCrc) begin
      crc_nxt = crc8_byte(crc_r, b);
    end
    // little-endian words fill from the top byte down
    if (pos_r >= 5'd1 && pos_r <= 5'd4) begin
      sec_nxt = {b, sec_r[31:8]};
    end else if (pos_r >= 5'd5 && pos_r <= 5'd8) begin
      ms_nxt = {b, ms_r[31:8]};
    end else if (pos_r >= 5'd9 && pos_r <= 5'd12) begin
      x_nxt = {b, x_r[31:8]};
    end else if (pos_r >= 5'd13 && pos_r <= 5'd16) begin
      y_nxt = {b, y_r[31:8]};
    end else if (pos_r >= 5'd17 && pos_r <= PosLastCrc) begin
      yaw_nxt = {b, yaw_r[31:8]};
    end else if (pos_r == PosCrc) begin
      rx_crc_nxt = b;
    end
    pos_nxt = count;

    if (count != 5'(FrameBytes)) begin
      status_nxt = ST_LENGTH;
    end else if (!hdr_ok_nxt) begin
      status_nxt = ST_HEADER;
    end else if (b != TrailerByte) begin
      status_nxt = ST_TRAILER;
    end else if (crc_nxt != rx_crc_nxt) begin
      status_nxt = ST_CRC;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 5'd0;
      crc_r    <= CrcInit;
      hdr_ok_r <= 1'b0;
    end else if (take) begin
      if (s_item.last_byte) begin
        pos_r    <= 5'd0;
        crc_r    <= CrcInit;
        hdr_ok_r <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        crc_r    <= crc_nxt;
        hdr_ok_r <= hdr_ok_nxt;
      end
    end
  end

  // word registers are fully rewritten in any frame of the right length
  always_ff @(posedge clk) begin
    if (take) begin
      rx_crc_r <= rx_crc_nxt;
      sec_r    <= sec_nxt;
      ms_r     <= ms_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      yaw_r    <= yaw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r <= status_nxt;
      if (status_nxt == ST_OK) begin
        o_sec_r <= sec_nxt;
        o_ms_r  <= ms_nxt;
        o_x_r   <= x_nxt;
        o_y_r   <= y_nxt;
        o_yaw_r <= yaw_nxt;
      end else begin
        o_sec_r <= 32'd0;
        o_ms_r  <= 32'd0;
        o_x_r   <= 32'd0;
        o_y_r   <= 32'd0;
        o_yaw_r <= 32'd0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_status  = status_r;
  assign out_stamp_seconds = o_sec_r;
  assign out_stamp_millis  = o_ms_r;
  assign out_pos_x_bits    = o_x_r;
  assign out_pos_y_bits    = o_y_r;
  assign out_heading_bits  = o_yaw_r;

endmodule

// ----- src/odometry_frame_crc8_parser_core.sv -----
// top level of the odometry frame parser with crc-8 check
// Takes one buffer byte per item, one item per clock, with in_last_byte on the final byte of
// each buffer. A 23-byte frame ('X', five little-endian 32-bit words, reflected crc-8 over
// bytes 0 to 20, newline) is checked and on the last byte one result item carries the status
// (0 ok, 1 length, 2 header, 3 trailer, 4 crc) and the words, all zero unless ok; other bytes
// give no result. Bytes flow at one per cycle, unless a held result stalls them, through an
// input register and the frame logic, which update crc and byte counter per byte; a last byte
// loads the result register. Only a last byte waits while an untaken result is held.
module odometry_frame_crc8_parser_core
  import ofcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_frame_status,
  output logic [31:0] out_stamp_seconds,
  output logic [31:0] out_stamp_millis,
  output logic [31:0] out_pos_x_bits,
  output logic [31:0] out_pos_y_bits,
  output logic [31:0] out_heading_bits
);

  byte_item_t in_item;
  byte_item_t s_item;
  logic       s_valid;
  logic       s_ready;

  assign in_item.data_byte = in_data_byte;
  assign in_item.last_byte = in_last_byte;

  ofcp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_item   (s_item)
  );

  ofcp_frame_chk u_frame_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_item            (s_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_status  (out_frame_status),
    .out_stamp_seconds (out_stamp_seconds),
    .out_stamp_millis  (out_stamp_millis),
    .out_pos_x_bits    (out_pos_x_bits),
    .out_pos_y_bits    (out_pos_y_bits),
    .out_heading_bits  (out_heading_bits)
  );

`ifndef SYNTHESIS
  // failed frames carry no words
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_status != ST_OK) |->
      (out_stamp_seconds == 32'd0) && (out_stamp_millis == 32'd0) &&
      (out_pos_x_bits == 32'd0) && (out_pos_y_bits == 32'd0) &&
      (out_heading_bits == 32'd0))
    else $error("failed frame result carries non-zero words");

  // input only stalls behind a held byte
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s_valid && s_item.last_byte)
    else $error("input stalled without a held last byte");

  // a new result only comes from a last byte taken by the frame logic
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s_valid && s_ready && s_item.last_byte))
    else $error("result raised without a last byte");
`endif

endmodule
